[hw/rtl/isolated_value_counter_defines.svh]
// Assertion helpers shared by the RTL.
// Each macro samples on the rising edge of clk and is off while rst_n is low.
`ifndef ISOLATED_VALUE_COUNTER_DEFINES_SVH
`define ISOLATED_VALUE_COUNTER_DEFINES_SVH

// same-cycle implication
`define IVC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define IVC_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/ivc_pkg.sv]
package ivc_pkg;

    // frame geometry and sample format
    localparam int MAX_COLS     = 1024;
    localparam int MAX_ROWS     = 1024;
    localparam int SAMPLE_WIDTH = 16;

    localparam int COL_W   = $clog2(MAX_COLS);
    localparam int ROW_W   = $clog2(MAX_ROWS);
    localparam int SIZE_W  = 11;   // width of the size registers
    localparam int COUNT_W = 20;
    localparam int CFG_W   = 16;   // widest register
    localparam int CFG_IDX_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TARGET_VALUE = 2'd0,
        REG_NUM_ROWS     = 2'd1,
        REG_NUM_COLS     = 2'd2
    } cfg_reg_t;

    localparam logic [SIZE_W-1:0] ROWS_RESET = SIZE_W'(5);
    localparam logic [SIZE_W-1:0] COLS_RESET = SIZE_W'(5);

endpackage

[hw/rtl/isolated_value_counter.sv]
// Channel  | direction | handshake                    | payload
// ---------+-----------+------------------------------+------------------------------
// input    | in        | in_valid / in_stall          | pixel_value (16b signed)
// output   | out       | out_valid / out_stall        | isolated_count (20b unsigned)
// config   | in        | cfg_write_en (no wait)       | cfg_index (2b), cfg_data (16b)
//
// One pixel request per cycle, sustained while in_stall is low. A request is read
// out of the line stores in the cycle it is taken and finished in stage B, where a
// frame-end request can be held; the frame count shows on the output register the cycle after B.
// Throughput is set by the middle line store: one write and two reads per cycle.
// Reset clears control state only; line stores need no clearing pass.
// in_stall rises only while a frame-end request waits for a full, stalled output
// register; a pending result otherwise does not block new requests.
`include "isolated_value_counter_defines.svh"

module isolated_value_counter
(
    input  logic                                   clk,
    input  logic                                   rst_n,

    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic signed [ivc_pkg::SAMPLE_WIDTH-1:0] pixel_value,

    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic [ivc_pkg::COUNT_W-1:0]            isolated_count,

    input  logic                                   cfg_write_en,
    input  logic [ivc_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [ivc_pkg::CFG_W-1:0]              cfg_data
);

    localparam int SW = ivc_pkg::SAMPLE_WIDTH;
    localparam int CW = ivc_pkg::COL_W;
    localparam int RW = ivc_pkg::ROW_W;
    localparam int ZW = ivc_pkg::SIZE_W;
    localparam int NW = ivc_pkg::COUNT_W;

    localparam logic [ZW-1:0] MAX_COLS_Z = ZW'(ivc_pkg::MAX_COLS);
    localparam logic [ZW-1:0] MAX_ROWS_Z = ZW'(ivc_pkg::MAX_ROWS);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [SW-1:0] target_reg;
    logic [ZW-1:0] rows_reg;
    logic [ZW-1:0] cols_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg <= '0;
            rows_reg   <= ivc_pkg::ROWS_RESET;
            cols_reg   <= ivc_pkg::COLS_RESET;
        end
        else if (cfg_write_en)
        begin
            unique case (ivc_pkg::cfg_reg_t'(cfg_index))
                ivc_pkg::REG_TARGET_VALUE: target_reg <= cfg_data[SW-1:0];
                ivc_pkg::REG_NUM_ROWS:     rows_reg   <= cfg_data[ZW-1:0];
                ivc_pkg::REG_NUM_COLS:     cols_reg   <= cfg_data[ZW-1:0];
                default:                   ;   // unused index: write dropped
            endcase
        end
    end

    // Effective sizes: zero means one, oversize saturates.
    logic [ZW-1:0] rows_eff;
    logic [ZW-1:0] cols_eff;

    always_comb
    begin
        if (rows_reg == '0)
            rows_eff = ZW'(1);
        else if (rows_reg > MAX_ROWS_Z)
            rows_eff = MAX_ROWS_Z;
        else
            rows_eff = rows_reg;

        if (cols_reg == '0)
            cols_eff = ZW'(1);
        else if (cols_reg > MAX_COLS_Z)
            cols_eff = MAX_COLS_Z;
        else
            cols_eff = cols_reg;
    end

    // ------------------------------------------------------------------
    // Stage A: position bookkeeping and line store reads
    // ------------------------------------------------------------------
    logic [CW-1:0] col_index_reg;
    logic [RW-1:0] row_index_reg;

    logic          in_accept;
    logic [CW-1:0] a_c;       // clamped column
    logic [CW-1:0] a_c1;      // column to the right (don't care on last column)
    logic [RW-1:0] a_r;       // clamped row
    logic          a_last_col;
    logic          a_last_row;
    logic          a_interior;

    // Stage B status, declared early for the hazard checks
    logic          b_valid_reg;
    logic [CW-1:0] b_c_reg;
    logic [SW-1:0] b_px_reg;
    logic          b_interior_reg;
    logic          b_last_col_reg;
    logic          b_frame_end_reg;
    logic          b_hold;
    logic          b_fire;
    logic [SW-1:0] b_mid_c;   // middle row at b_c before this request overwrites it

    logic          out_valid_reg;
    logic [NW-1:0] out_count_reg;

    // A frame-end request cannot leave B while the output register is held.
    assign b_hold    = b_valid_reg && b_frame_end_reg && out_valid_reg && out_stall;
    assign b_fire    = b_valid_reg && !b_hold;
    assign in_stall  = b_hold;
    assign in_accept = in_valid && !in_stall;

    always_comb
    begin
        if (ZW'(col_index_reg) < cols_eff)
            a_c = col_index_reg;
        else
            a_c = CW'(cols_eff - ZW'(1));

        if (ZW'(row_index_reg) < rows_eff)
            a_r = row_index_reg;
        else
            a_r = RW'(rows_eff - ZW'(1));

        a_c1       = a_c + CW'(1);
        a_last_col = (ZW'(a_c) + ZW'(1)) >= cols_eff;
        a_last_row = (ZW'(a_r) + ZW'(1)) >= rows_eff;
        // centre (r-1, c) has all four neighbours inside the frame
        a_interior = (a_r >= RW'(2)) && (a_c != '0) && !a_last_col;
    end

    logic [CW-1:0] col_index_next;
    logic [RW-1:0] row_index_next;

    always_comb
    begin
        col_index_next = col_index_reg;
        row_index_next = row_index_reg;
        if (in_accept)
        begin
            if (!a_last_col)
            begin
                col_index_next = a_c1;
                row_index_next = a_r;
            end
            else
            begin
                col_index_next = '0;
                row_index_next = a_last_row ? '0 : a_r + RW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_index_reg <= '0;
            row_index_reg <= '0;
        end
        else
        begin
            col_index_reg <= col_index_next;
            row_index_reg <= row_index_next;
        end
    end

    // ------------------------------------------------------------------
    // Line stores: upper row and middle row, one synchronous write port,
    // registered reads (old data on a same-edge write).
    // ------------------------------------------------------------------
    logic [SW-1:0] upper_mem  [ivc_pkg::MAX_COLS];
    logic [SW-1:0] middle_mem [ivc_pkg::MAX_COLS];

    logic [SW-1:0] upper_rd_reg;
    logic [SW-1:0] mid_c_rd_reg;
    logic [SW-1:0] mid_r_rd_reg;

    always_ff @(posedge clk)
    begin
        if (b_fire)
            upper_mem[b_c_reg] <= b_mid_c;
        if (in_accept)
            upper_rd_reg <= upper_mem[a_c];
    end

    always_ff @(posedge clk)
    begin
        if (b_fire)
            middle_mem[b_c_reg] <= b_px_reg;
        if (in_accept)
        begin
            mid_c_rd_reg <= middle_mem[a_c];
            mid_r_rd_reg <= middle_mem[a_c1];
        end
    end

    // Forwarding: the request leaving B writes the entry a new read may hit
    // (single-column frames, two-column wrap, clamped positions).
    logic          fwd_up_reg;
    logic          fwd_mc_reg;
    logic          fwd_mr_reg;
    logic [SW-1:0] fwd_up_data_reg;
    logic [SW-1:0] fwd_px_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_up_reg <= 1'b0;
            fwd_mc_reg <= 1'b0;
            fwd_mr_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            fwd_up_reg <= b_fire && (b_c_reg == a_c);
            fwd_mc_reg <= b_fire && (b_c_reg == a_c);
            fwd_mr_reg <= b_fire && (b_c_reg == a_c1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            fwd_up_data_reg <= b_mid_c;
            fwd_px_data_reg <= b_px_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage B: stencil test, window shift, write-back, count
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg     <= 1'b0;
            b_interior_reg  <= 1'b0;
            b_last_col_reg  <= 1'b0;
            b_frame_end_reg <= 1'b0;
            b_c_reg         <= '0;
        end
        else
        begin
            b_valid_reg <= in_accept || b_hold;
            if (in_accept)
            begin
                b_interior_reg  <= a_interior;
                b_last_col_reg  <= a_last_col;
                b_frame_end_reg <= a_last_col && a_last_row;
                b_c_reg         <= a_c;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
            b_px_reg <= pixel_value;
    end

    logic [SW-1:0] b_above;
    logic [SW-1:0] b_right;
    logic          b_match;

    assign b_above = fwd_up_reg ? fwd_up_data_reg : upper_rd_reg;
    assign b_mid_c = fwd_mc_reg ? fwd_px_data_reg : mid_c_rd_reg;
    assign b_right = fwd_mr_reg ? fwd_px_data_reg : mid_r_rd_reg;

    logic [SW-1:0] mid_left_reg;
    logic [SW-1:0] mid_centre_reg;
    logic [SW-1:0] row_first_reg;   // column-zero sample of the current row
    logic [NW-1:0] match_count_reg;

    // centre from the window, left from the window, below is the new pixel
    assign b_match = b_interior_reg
                  && (mid_centre_reg == target_reg)
                  && (mid_left_reg   != target_reg)
                  && (b_right        != target_reg)
                  && (b_above        != target_reg)
                  && (b_px_reg       != target_reg);

    logic [SW-1:0] mid_left_next;
    logic [SW-1:0] mid_centre_next;
    logic [NW-1:0] match_count_next;

    always_comb
    begin
        mid_left_next    = mid_left_reg;
        mid_centre_next  = mid_centre_reg;
        match_count_next = match_count_reg;
        if (b_fire)
        begin
            if (!b_last_col_reg)
            begin
                mid_left_next   = mid_centre_reg;
                mid_centre_next = b_right;
            end
            else
            begin
                // next row's window opens on this row's first sample
                mid_left_next   = '0;
                mid_centre_next = (b_c_reg == '0) ? b_px_reg : row_first_reg;
            end

            if (b_frame_end_reg)
                match_count_next = '0;
            else if (b_match)
                match_count_next = match_count_reg + NW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mid_left_reg    <= '0;
            mid_centre_reg  <= '0;
            match_count_reg <= '0;
        end
        else
        begin
            mid_left_reg    <= mid_left_next;
            mid_centre_reg  <= mid_centre_next;
            match_count_reg <= match_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (b_fire && (b_c_reg == '0))
            row_first_reg <= b_px_reg;
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    logic out_load;

    // at a frame end the last column never matches, so the running count is final
    assign out_load = b_fire && b_frame_end_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (out_valid_reg && !out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
            out_count_reg <= match_count_reg;
    end

    assign out_valid      = out_valid_reg;
    assign isolated_count = out_count_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `IVC_ASSERT_NXT(a_count_cleared, out_load, match_count_reg == '0, "count not cleared at frame end")
    `IVC_ASSERT_NXT(a_col_wraps, in_accept && a_last_col, col_index_reg == '0, "column did not wrap")
    `IVC_ASSERT_NXT(a_hold_keeps, b_hold, b_valid_reg && $stable(b_c_reg), "held request lost")

endmodule

[test/tb_isolated_value_counter.sv]
`timescale 1ns / 100ps

// Drives pixel requests through the isolated value counter, predicts one frame
// count per finished frame and checks every count the block returns.
module tb_isolated_value_counter;

    localparam int SW = ivc_pkg::SAMPLE_WIDTH;
    localparam int ZW = ivc_pkg::SIZE_W;
    localparam int NW = ivc_pkg::COUNT_W;
    localparam int FW = ivc_pkg::CFG_W;
    localparam int IW = ivc_pkg::CFG_IDX_W;

    // register index that maps to no register; a write to it must change nothing
    localparam logic [IW-1:0] REG_SPARE = 2'd3;

    localparam int RANDOM_ITEMS = 200;
    localparam int SETTLE       = 6;       // request in, line read, count out, margin
    localparam int LONG_HOLD    = 300;     // output held off long enough to back up input
    localparam int LIMIT        = 400000;
    localparam int MAX_PRINTS   = 100;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic in_valid = 1'b0;
    logic in_stall;
    logic signed [SW-1:0] pixel_value = '0;

    logic out_valid;
    logic out_stall = 1'b0;
    logic [NW-1:0] isolated_count;

    logic cfg_write_en = 1'b0;
    logic [IW-1:0] cfg_index = '0;
    logic [FW-1:0] cfg_data = '0;

    isolated_value_counter uut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .pixel_value    (pixel_value),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .isolated_count (isolated_count),
        .cfg_write_en   (cfg_write_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Stencil predictor: our own copy of registers, line stores and window.
    // Values start at the block's reset state; reset is applied only once.
    // ------------------------------------------------------------------
    logic [SW-1:0] target_cfg = '0;
    logic [ZW-1:0] rows_cfg   = ivc_pkg::ROWS_RESET;
    logic [ZW-1:0] cols_cfg   = ivc_pkg::COLS_RESET;

    bit [SW-1:0] upper_row  [0:ivc_pkg::MAX_COLS-1];
    bit [SW-1:0] middle_row [0:ivc_pkg::MAX_COLS-1];
    bit [SW-1:0] win_left   = '0;
    bit [SW-1:0] win_centre = '0;
    int unsigned col_pos = 0;
    int unsigned row_pos = 0;
    bit [NW-1:0] running_count = '0;

    // size register as the block sees it: zero acts as one, oversize saturates
    function automatic int unsigned eff_size(input logic [ZW-1:0] v, input int unsigned cap);
        int unsigned vi;
        vi = 32'(v);
        if (vi == 0)
            return 1;
        if (vi > cap)
            return cap;
        return vi;
    endfunction

    // Advance the window by one pixel. Returns 1 with the frame count in total
    // when this pixel closes the frame.
    function automatic bit stencil_step(input logic [SW-1:0] px,
                                        output logic [NW-1:0] total);
        int unsigned rows_eff;
        int unsigned cols_eff;
        int unsigned c;
        int unsigned r;
        bit [SW-1:0] right_px;
        bit [SW-1:0] above_px;
        bit last_col;
        bit last_row;
        bit done;
        rows_eff = eff_size(rows_cfg, ivc_pkg::MAX_ROWS);
        cols_eff = eff_size(cols_cfg, ivc_pkg::MAX_COLS);
        // a position past a shrunken size counts as the last column / row
        c = (col_pos < cols_eff) ? col_pos : cols_eff - 1;
        r = (row_pos < rows_eff) ? row_pos : rows_eff - 1;
        last_col = (c + 1 >= cols_eff);
        last_row = (r + 1 >= rows_eff);
        above_px = upper_row[c];
        right_px = last_col ? '0 : middle_row[c + 1];
        done = 1'b0;
        total = '0;

        // centre is (r-1, c): left/right on the middle row, above from upper,
        // below is the incoming pixel
        if (r >= 2 && c >= 1 && !last_col && win_centre == target_cfg &&
            win_left != target_cfg && right_px != target_cfg &&
            above_px != target_cfg && px != target_cfg)
            running_count = running_count + NW'(1);

        upper_row[c]  = middle_row[c];
        middle_row[c] = px;

        if (!last_col)
        begin
            win_left   = win_centre;
            win_centre = right_px;
            col_pos    = c + 1;
            row_pos    = r;
        end
        else
        begin
            win_left   = '0;
            win_centre = middle_row[0];
            col_pos    = 0;
            if (last_row)
            begin
                total         = running_count;
                done          = 1'b1;
                running_count = '0;
                row_pos       = 0;
            end
            else
                row_pos = r + 1;
        end
        return done;
    endfunction

    // ------------------------------------------------------------------
    // Shared bookkeeping
    // ------------------------------------------------------------------
    logic [SW-1:0] pending_pixels [$];   // requests not yet offered
    logic [NW-1:0] frame_counts   [$];   // predicted counts in flight
    int pushed_total   = 0;      // written by stimulus only
    int accepted_total = 0;      // written by driver only
    int idle_odds      = 0;      // 1-in-N chance of a sender gap, 0 = none
    int stall_odds     = 0;      // 1-in-N chance of a receiver stall, 0 = none
    int hold_asks      = 0;      // bumped by stimulus to request one long hold
    int error_count    = 0;
    int cycle_count    = 0;

    logic [NW-1:0] finished_count;
    logic [NW-1:0] oldest_count;

    task automatic report_mismatch(input string what);
        error_count++;
        if (error_count <= MAX_PRINTS)
            $display("mismatch at cycle %0d: %s", cycle_count, what);
    endtask

    // ------------------------------------------------------------------
    // Request driver. A stalled request holds; otherwise the next one is
    // offered unless a random gap is running.
    // ------------------------------------------------------------------
    int gap_left = 0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid    <= 1'b0;
            pixel_value <= '0;
            gap_left    <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                accepted_total++;
                if (stencil_step(pixel_value, finished_count))
                    frame_counts.push_back(finished_count);
            end

            if (in_valid && in_stall)
                ;   // request held until taken
            else if (gap_left != 0)
            begin
                in_valid <= 1'b0;
                gap_left <= gap_left - 1;
            end
            else if (pending_pixels.size() != 0 && idle_odds != 0 &&
                     $urandom_range(1, idle_odds) == 1)
            begin
                in_valid <= 1'b0;
                gap_left <= int'($urandom_range(0, 18));
            end
            else if (pending_pixels.size() != 0)
            begin
                in_valid    <= 1'b1;
                pixel_value <= pending_pixels.pop_front();
            end
            else
                in_valid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Receiver stall: random bursts, plus one long hold on request that
    // lets frame ends pile up until the block stalls its input.
    // ------------------------------------------------------------------
    int stall_left = 0;
    int hold_seen  = 0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall  <= 1'b0;
            stall_left <= 0;
            hold_seen  <= 0;
        end
        else if (hold_seen != hold_asks)
        begin
            hold_seen  <= hold_asks;
            out_stall  <= 1'b1;
            stall_left <= LONG_HOLD - 1;
        end
        else if (stall_left != 0)
        begin
            out_stall  <= 1'b1;
            stall_left <= stall_left - 1;
        end
        else if (stall_odds != 0 && $urandom_range(1, stall_odds) == 1)
        begin
            out_stall  <= 1'b1;
            stall_left <= int'($urandom_range(0, 18));
        end
        else
            out_stall <= 1'b0;
    end

    // ------------------------------------------------------------------
    // Result monitor: every taken count against the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (frame_counts.size() == 0)
                report_mismatch($sformatf("count %0d with no frame pending", isolated_count));
            else
            begin
                oldest_count = frame_counts.pop_front();
                if (isolated_count !== oldest_count)
                    report_mismatch($sformatf("isolated_count %0d, predicted %0d",
                                              isolated_count, oldest_count));
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT)
        begin
            $display("tb_isolated_value_counter failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    logic [SW-1:0] background_px = '0;   // per-phase filler value
    int unsigned ready_cols = 0;   // columns both line stores hold written data for

    task automatic push_pixel(input logic [SW-1:0] v);
        pending_pixels.push_back(v);
        pushed_total++;
    endtask

    // wait until every request is taken and every count has come back,
    // then let the pipeline run empty before touching registers
    task automatic wait_drained();
        while (accepted_total != pushed_total || frame_counts.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input logic [IW-1:0] idx, input logic [FW-1:0] data);
        @(posedge clk);
        cfg_write_en <= 1'b1;
        cfg_index    <= idx;
        cfg_data     <= data;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        case (idx)
            ivc_pkg::REG_TARGET_VALUE: target_cfg = data[SW-1:0];
            ivc_pkg::REG_NUM_ROWS:     rows_cfg   = data[ZW-1:0];
            ivc_pkg::REG_NUM_COLS:     cols_cfg   = data[ZW-1:0];
            default:                   ;
        endcase
    endtask

    // size writes carry random junk above the register width
    task automatic program_frame(input logic [SW-1:0] tgt,
                                 input logic [ZW-1:0] rows,
                                 input logic [ZW-1:0] cols);
        logic [FW-1:0] word;
        write_reg(ivc_pkg::REG_TARGET_VALUE, FW'(tgt));
        word = FW'($urandom);
        word[ZW-1:0] = rows;
        write_reg(ivc_pkg::REG_NUM_ROWS, word);
        word = FW'($urandom);
        word[ZW-1:0] = cols;
        write_reg(ivc_pkg::REG_NUM_COLS, word);
        background_px = SW'($urandom);
    endtask

    function automatic logic [SW-1:0] pick_target();
        case ($urandom_range(0, 5))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'h0000;
            3:       return 16'hFFFF;
            default: return SW'($urandom);
        endcase
    endfunction

    function automatic logic [ZW-1:0] pick_size();
        case ($urandom_range(0, 19))
            0:       return ZW'(0);
            1:       return ZW'(1);
            2:       return ZW'(2);
            3:       return ZW'($urandom_range(9, 24));
            default: return ZW'($urandom_range(3, 8));
        endcase
    endfunction

    // Heavy on the target so isolated cells actually occur; single-bit
    // near misses catch sloppy compares; full-range noise toggles every bit.
    function automatic logic [SW-1:0] pick_sample();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return target_cfg;
            4, 5:       return target_cfg ^ (16'h1 << $urandom_range(0, 15));
            6, 7:       return background_px;
            default:    return SW'($urandom);
        endcase
    endfunction

    task automatic push_frames(input int frames);
        int unsigned rows_eff;
        int unsigned cols_eff;
        rows_eff = eff_size(rows_cfg, ivc_pkg::MAX_ROWS);
        cols_eff = eff_size(cols_cfg, ivc_pkg::MAX_COLS);
        repeat (frames * rows_eff * cols_eff)
            push_pixel(pick_sample());
        wait_drained();
        if (rows_eff >= 2 && cols_eff > ready_cols)
            ready_cols = cols_eff;
    endtask

    // Stop part way through a frame, resize while idle, then finish the frame
    // at the new size. Columns only grow into line entries already written.
    task automatic resize_mid_frame();
        int unsigned rows_eff;
        int unsigned cols_eff;
        int unsigned hi;
        int unsigned c;
        int unsigned r;
        program_frame(pick_target(), ZW'($urandom_range(2, 8)), ZW'($urandom_range(1, 8)));
        rows_eff = eff_size(rows_cfg, ivc_pkg::MAX_ROWS);
        cols_eff = eff_size(cols_cfg, ivc_pkg::MAX_COLS);
        repeat ($urandom_range(1, rows_eff * cols_eff - 1))
            push_pixel(pick_sample());
        wait_drained();

        hi = (cols_eff > ready_cols) ? cols_eff : ready_cols;
        if (hi > 12)
            hi = 12;
        write_reg(ivc_pkg::REG_NUM_COLS, FW'($urandom_range(0, hi)));
        write_reg(ivc_pkg::REG_NUM_ROWS, FW'($urandom_range(0, 10)));
        if ($urandom_range(0, 1) == 1)
            write_reg(ivc_pkg::REG_TARGET_VALUE, FW'(pick_target()));

        // requests left in the frame from where the window stands now
        rows_eff = eff_size(rows_cfg, ivc_pkg::MAX_ROWS);
        cols_eff = eff_size(cols_cfg, ivc_pkg::MAX_COLS);
        c = (col_pos < cols_eff) ? col_pos : cols_eff - 1;
        r = (row_pos < rows_eff) ? row_pos : rows_eff - 1;
        repeat ((rows_eff - 1 - r) * cols_eff + (cols_eff - c))
            push_pixel(pick_sample());
        wait_drained();
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        logic [SW-1:0] v;
        int loop_start;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset geometry (5x5, target 0): zeros on the even checkerboard are
        // isolated, odd cells alternate the two extremes. One extra zero next
        // to the middle breaks isolation for its neighbours.
        for (int r = 0; r < 5; r++)
            for (int c = 0; c < 5; c++)
            begin
                if ((r + c) % 2 == 0 || (r == 2 && c == 3))
                    v = '0;
                else
                    v = (r % 2 == 1) ? 16'h8000 : 16'h7FFF;
                push_pixel(v);
            end
        wait_drained();

        // zero sizes act as 1x1: every request ends a frame with count 0
        write_reg(ivc_pkg::REG_NUM_ROWS, '0);
        write_reg(ivc_pkg::REG_NUM_COLS, '0);
        push_pixel('0);
        push_pixel(16'hFFFF);
        wait_drained();

        // a write to the unused index must leave the registers alone
        write_reg(REG_SPARE, FW'($urandom));
        push_pixel(SW'($urandom));
        wait_drained();

        // Backpressure: output held for a long stretch while 3x3 frames keep
        // coming, so a second frame end waits and the input stalls.
        program_frame(pick_target(), ZW'(3), ZW'(3));
        hold_asks++;
        push_frames(10);

        // oversize columns saturate to the line store depth: one full-width row
        idle_odds  = 6;
        stall_odds = 6;
        program_frame(pick_target(), ZW'(1), ZW'(2047));
        push_frames(1);

        loop_start = pushed_total;
        while (pushed_total - loop_start < RANDOM_ITEMS)
        begin
            idle_odds  = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(2, 10));
            stall_odds = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(2, 10));
            if ($urandom_range(0, 7) == 0)
                resize_mid_frame();
            else
            begin
                program_frame(pick_target(), pick_size(), pick_size());
                push_frames(int'($urandom_range(1, 3)));
            end
        end

        // closing stretch at full rate on both sides
        idle_odds  = 0;
        stall_odds = 0;
        program_frame(pick_target(), ZW'($urandom_range(3, 6)), ZW'($urandom_range(3, 6)));
        push_frames(3);

        if (error_count == 0)
            $display("tb_isolated_value_counter passed");
        else
            $display("tb_isolated_value_counter failed");
        $finish;
    end

endmodule
